@@ rtl/hbpam_pkg.sv @@
// Package for the host bridge PAM shadow control block.
// Holds function and target codes, the shared route struct and the config reset values.
// No dependencies.
package hbpam_pkg;

  typedef enum logic [1:0] {
    FUNC_CFG_RD = 2'd0,
    FUNC_CFG_WR = 2'd1,
    FUNC_MEM_RD = 2'd2,
    FUNC_MEM_WR = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    TGT_RAM     = 2'd0,
    TGT_ROM     = 2'd1,
    TGT_DROPPED = 2'd2,
    TGT_NONE    = 2'd3
  } target_t;

  localparam logic [2:0] REGION_E0000 = 3'd0;
  localparam logic [2:0] REGION_F0000 = 3'd4;

  // Byte addresses of the PAM registers in configuration space.
  localparam logic [7:0] PAM_F0000_ADDR = 8'h59;
  localparam logic [7:0] PAM_E0_E4_ADDR = 8'h5E;
  localparam logic [7:0] PAM_E8_EC_ADDR = 8'h5F;

  localparam int unsigned PAM_LOW_RD_BIT  = 0;
  localparam int unsigned PAM_LOW_WR_BIT  = 1;
  localparam int unsigned PAM_HIGH_RD_BIT = 4;
  localparam int unsigned PAM_HIGH_WR_BIT = 5;

  localparam logic [7:0] CFG_RST_LO  = 8'h60;
  localparam logic [7:0] CFG_RST_HI  = 8'h65;
  localparam logic [7:0] CFG_RST_VAL = 8'h02;

  typedef struct packed {
    logic [1:0]  target;
    logic [2:0]  region;
    logic [17:0] offset;
  } route_t;

  // Reset value of one configuration byte.
  function automatic logic [7:0] cfg_reset_byte(input logic [7:0] addr);
    logic [7:0] val;
    val = 8'h00;
    if (addr >= CFG_RST_LO && addr <= CFG_RST_HI) begin
      val = CFG_RST_VAL;
    end
    return val;
  endfunction

endpackage

@@ rtl/hbpam_if.sv @@
// Valid/ready channel interfaces for the host bridge PAM shadow control block.
// Depends on nothing but the payload widths of the block.
interface hbpam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [5:0]  cfg_index;
  logic [3:0]  byte_enable;
  logic [31:0] write_data;
  logic [31:0] mem_address;

  modport source (output valid, func, cfg_index, byte_enable, write_data, mem_address,
                  input ready);
  modport sink (input valid, func, cfg_index, byte_enable, write_data, mem_address,
                output ready);
endinterface

interface hbpam_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [1:0]  target;
  logic [2:0]  ram_region;
  logic [17:0] mem_offset;

  modport source (output valid, read_data, target, ram_region, mem_offset, input ready);
  modport sink (input valid, read_data, target, ram_region, mem_offset, output ready);
endinterface

@@ rtl/host_bridge_pam_shadow_control_top.sv @@
// Top level of the host bridge PAM shadow control block.
// Depends on hbpam_pkg, the hbpam_in_if/hbpam_out_if interfaces and hbpam_route.
//
// One input channel carries bus accesses: config reads and writes to a
// 256-byte configuration space (dword index plus byte enables), and memory
// reads and writes whose address is decoded against the PAM bytes 0x59,
// 0x5E and 0x5F. Every accepted item produces exactly one result item on
// the output channel, in order.
// From input handshake to output handshake an item passes the middle stage,
// which holds the config store read (or the routing decode), and then the
// output register.
// Throughput is one item per cycle while the receiver is ready; config writes
// take effect at the edge they are accepted, so the next item already sees them.
// The config store is a 64 x 32 memory with per-byte valid bits; a byte
// never written reads as its reset value (zero, or 0x02 for 0x60-0x65), so
// no clearing pass is needed after reset.
// Reset empties both pipeline stages and clears the PAM bytes and valid bits.
// When the receiver stalls, the output holds its item, the middle stage
// fills, and only then does in.ready drop.
module host_bridge_pam_shadow_control_top
  import hbpam_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hbpam_in_if.sink     in_ch,
  hbpam_out_if.source  out_ch
);

  logic [3:0][7:0] mem_r [64];
  logic [255:0]    byte_vld_r;
  logic [7:0]      pam59_r;
  logic [7:0]      pam5e_r;
  logic [7:0]      pam5f_r;

  logic            in_accept;
  logic            s1_adv;
  logic            is_cfg_wr;
  logic            is_cfg_rd;
  route_t          route_in;

  logic            s1_v_r;
  logic [1:0]      s1_func_r;
  logic [5:0]      s1_idx_r;
  logic [3:0]      s1_be_r;
  logic [3:0][7:0] s1_rdata_r;
  logic [3:0]      s1_vld_r;
  route_t          s1_route_r;

  logic            out_v_r;
  logic [31:0]     out_rdata_r;
  route_t          out_route_r;
  logic [31:0]     rdata_nxt;
  route_t          route_nxt;

  assign s1_adv       = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || s1_adv;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign is_cfg_wr    = in_ch.func == FUNC_CFG_WR;
  assign is_cfg_rd    = in_ch.func == FUNC_CFG_RD;

  hbpam_route u_route (
    .addr     (in_ch.mem_address),
    .is_write (in_ch.func == FUNC_MEM_WR),
    .pam_59   (pam59_r),
    .pam_5e   (pam5e_r),
    .pam_5f   (pam5f_r),
    .route    (route_in)
  );

  // Config store: one row written with byte enables, one row read, registered.
  always_ff @(posedge clk) begin
    if (in_accept && is_cfg_wr) begin
      for (int l = 0; l < 4; l++) begin
        if (in_ch.byte_enable[l]) begin
          mem_r[in_ch.cfg_index][l] <= in_ch.write_data[8*l +: 8];
        end
      end
    end
    if (in_accept && is_cfg_rd) begin
      s1_rdata_r <= mem_r[in_ch.cfg_index];
    end
  end

  // Byte valid bits and the PAM copies used by the routing decode.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= '0;
      pam59_r    <= '0;
      pam5e_r    <= '0;
      pam5f_r    <= '0;
    end else if (in_accept && is_cfg_wr) begin
      for (int l = 0; l < 4; l++) begin
        if (in_ch.byte_enable[l]) begin
          byte_vld_r[{in_ch.cfg_index, 2'(l)}] <= 1'b1;
          if ({in_ch.cfg_index, 2'(l)} == PAM_F0000_ADDR) begin
            pam59_r <= in_ch.write_data[8*l +: 8];
          end
          if ({in_ch.cfg_index, 2'(l)} == PAM_E0_E4_ADDR) begin
            pam5e_r <= in_ch.write_data[8*l +: 8];
          end
          if ({in_ch.cfg_index, 2'(l)} == PAM_E8_EC_ADDR) begin
            pam5f_r <= in_ch.write_data[8*l +: 8];
          end
        end
      end
    end
  end

  // Middle stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_func_r  <= in_ch.func;
      s1_idx_r   <= in_ch.cfg_index;
      s1_be_r    <= in_ch.byte_enable;
      s1_route_r <= route_in;
      for (int l = 0; l < 4; l++) begin
        s1_vld_r[l] <= byte_vld_r[{in_ch.cfg_index, 2'(l)}];
      end
    end
  end

  always_comb begin
    rdata_nxt = '0;
    route_nxt = s1_route_r;
    if (s1_func_r == FUNC_CFG_RD || s1_func_r == FUNC_CFG_WR) begin
      route_nxt.target = TGT_NONE;
      route_nxt.region = REGION_E0000;
      route_nxt.offset = '0;
    end
    if (s1_func_r == FUNC_CFG_RD) begin
      for (int l = 0; l < 4; l++) begin
        if (s1_be_r[l]) begin
          rdata_nxt[8*l +: 8] = s1_vld_r[l] ? s1_rdata_r[l]
                                            : cfg_reset_byte({s1_idx_r, 2'(l)});
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_rdata_r <= rdata_nxt;
      out_route_r <= route_nxt;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.read_data  = out_rdata_r;
  assign out_ch.target     = out_route_r.target;
  assign out_ch.ram_region = out_route_r.region;
  assign out_ch.mem_offset = out_route_r.offset;

  // A result routed to RAM, ROM or dropped never carries read data.
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.target != TGT_NONE |-> out_ch.read_data == '0)
    else $error("read data set on a memory access result");

  // Input stalls only when both stages are full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_v_r && out_v_r && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

  // A write to byte 0x5E updates the E0000/E4000 control copy.
  a_pam5e_upd: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && is_cfg_wr && in_ch.cfg_index == PAM_E0_E4_ADDR[7:2]
      && in_ch.byte_enable[2] |=> pam5e_r == $past(in_ch.write_data[23:16]))
    else $error("PAM 0x5E copy not updated");

  // Region codes stay within the five shadow segments.
  a_region_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.ram_region <= REGION_F0000)
    else $error("region code out of range");

  // Results outside the window or from config accesses report region zero.
  a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.target == TGT_NONE
      |-> out_ch.ram_region == REGION_E0000 && out_ch.mem_offset == '0)
    else $error("stray routing fields on an unrouted result");

endmodule

@@ rtl/hbpam_route.sv @@
// Address decode for memory accesses in the E0000-FFFFF shadow window.
// Depends on hbpam_pkg for the route struct, codes and PAM bit positions.
module hbpam_route
  import hbpam_pkg::*;
(
  input  logic [31:0] addr,
  input  logic        is_write,
  input  logic [7:0]  pam_59,
  input  logic [7:0]  pam_5e,
  input  logic [7:0]  pam_5f,
  output route_t      route
);

  logic       in_window;
  logic       is_f_seg;
  logic [7:0] pam;
  logic       high_half;
  logic       rd_en;
  logic       wr_en;
  logic [17:0] ram_off;
  logic [2:0]  region;

  always_comb begin
    in_window = (addr[31:20] == 12'h000) && (addr[19:17] == 3'b111);
    is_f_seg  = addr[16];
    if (is_f_seg) begin
      region    = REGION_F0000;
      pam       = pam_59;
      high_half = 1'b1;
      ram_off   = {2'b00, addr[15:0]};
    end else begin
      region    = {1'b0, addr[15:14]};
      pam       = addr[15] ? pam_5f : pam_5e;
      high_half = addr[14];
      ram_off   = {4'b0000, addr[13:0]};
    end
    rd_en = high_half ? pam[PAM_HIGH_RD_BIT] : pam[PAM_LOW_RD_BIT];
    wr_en = high_half ? pam[PAM_HIGH_WR_BIT] : pam[PAM_LOW_WR_BIT];

    route.target = TGT_NONE;
    route.region = REGION_E0000;
    route.offset = '0;
    if (in_window) begin
      route.region = region;
      if (is_write) begin
        route.target = wr_en ? TGT_RAM : TGT_DROPPED;
        route.offset = ram_off;
      end else if (rd_en) begin
        route.target = TGT_RAM;
        route.offset = ram_off;
      end else begin
        // ROM image is addressed by the low 18 address bits.
        route.target = TGT_ROM;
        route.offset = addr[17:0];
      end
    end
  end

endmodule

@@ dv/host_bridge_pam_shadow_control_top_tb.sv @@
// Testbench for host_bridge_pam_shadow_control_top: config space accesses and PAM routing.
// Needs hbpam_pkg, the hbpam_in_if/hbpam_out_if interfaces and the block's RTL.
// An in-order scoreboard checks every result against a predictor kept in this file.
module host_bridge_pam_shadow_control_top_tb
  import hbpam_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  target;
    logic [2:0]  region;
    logic [17:0] offset;
  } bus_result_t;

  logic clk = 1'b0;
  logic rst_n;

  hbpam_in_if  in_if ();
  hbpam_out_if out_if ();

  host_bridge_pam_shadow_control_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  logic [7:0]  cfg_bytes [256];
  bus_result_t pending_results [$];
  int          send_idle_pct;
  int          recv_stall_pct;
  int          error_count;
  int          results_seen;
  int          func_count [4];
  int          route_count [4];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[host_bridge_pam_shadow_control_top] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("result %0d: %s is 0x%0h, expected 0x%0h", results_seen, field, got, want);
    error_count++;
  endtask

  // Computes the result of one access and applies any config write to the local store.
  function automatic bus_result_t predict_access(input func_t f, input logic [5:0] idx,
                                                 input logic [3:0] be, input logic [31:0] wdata,
                                                 input logic [31:0] addr);
    bus_result_t res;
    logic [7:0]  pam;
    logic [17:0] ram_off;
    int          rd_bit;
    int          wr_bit;
    res = '0;
    res.target = TGT_NONE;
    case (f)
      FUNC_CFG_RD: begin
        for (int lane = 0; lane < 4; lane++) begin
          if (be[lane]) begin
            res.read_data[8*lane +: 8] = cfg_bytes[int'(idx) * 4 + lane];
          end
        end
      end
      FUNC_CFG_WR: begin
        for (int lane = 0; lane < 4; lane++) begin
          if (be[lane]) begin
            cfg_bytes[int'(idx) * 4 + lane] = wdata[8*lane +: 8];
          end
        end
      end
      default: begin
        // The shadow window is 0xE0000..0xFFFFF with every upper bit clear.
        if (addr[31:20] == 12'h000 && addr[19:17] == 3'b111) begin
          if (addr[16]) begin
            res.region = REGION_F0000;
            pam = cfg_bytes[PAM_F0000_ADDR];
            rd_bit = PAM_HIGH_RD_BIT;
            wr_bit = PAM_HIGH_WR_BIT;
            ram_off = {2'b00, addr[15:0]};
          end else begin
            res.region = {1'b0, addr[15:14]};
            pam = addr[15] ? cfg_bytes[PAM_E8_EC_ADDR] : cfg_bytes[PAM_E0_E4_ADDR];
            rd_bit = addr[14] ? PAM_HIGH_RD_BIT : PAM_LOW_RD_BIT;
            wr_bit = addr[14] ? PAM_HIGH_WR_BIT : PAM_LOW_WR_BIT;
            ram_off = {4'h0, addr[13:0]};
          end
          if (f == FUNC_MEM_WR) begin
            res.target = pam[wr_bit] ? TGT_RAM : TGT_DROPPED;
            res.offset = ram_off;
          end else if (pam[rd_bit]) begin
            res.target = TGT_RAM;
            res.offset = ram_off;
          end else begin
            res.target = TGT_ROM;
            res.offset = addr[17:0];
          end
        end
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : scoreboard
    bus_result_t want;
    bus_result_t pred;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, read_data", out_if.read_data, 32'h0);
        end else begin
          want = pending_results.pop_front();
          if (out_if.read_data !== want.read_data)
            report_mismatch("read_data", out_if.read_data, want.read_data);
          if (out_if.target !== want.target)
            report_mismatch("target", 32'(out_if.target), 32'(want.target));
          if (out_if.ram_region !== want.region)
            report_mismatch("ram_region", 32'(out_if.ram_region), 32'(want.region));
          if (out_if.mem_offset !== want.offset)
            report_mismatch("mem_offset", 32'(out_if.mem_offset), 32'(want.offset));
        end
      end
      if (in_if.valid && in_if.ready) begin
        pred = predict_access(func_t'(in_if.func), in_if.cfg_index, in_if.byte_enable,
                              in_if.write_data, in_if.mem_address);
        pending_results.push_back(pred);
        func_count[in_if.func]++;
        if (in_if.func[1]) begin
          route_count[pred.target]++;
        end
      end
    end
  end

  // The receiver decides its ready for each cycle at the falling edge.
  always @(negedge clk) begin
    out_if.ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  // Entered and left at a falling edge; valid stays high for a following item.
  task automatic send_access(input func_t f, input logic [5:0] idx, input logic [3:0] be,
                             input logic [31:0] wdata, input logic [31:0] addr);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.func        = f;
    in_if.cfg_index   = idx;
    in_if.byte_enable = be;
    in_if.write_data  = wdata;
    in_if.mem_address = addr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_config_defaults();
    // Bytes 0x60..0x65 come out of reset as 0x02, everything else as zero.
    send_access(FUNC_CFG_RD, 6'h18, 4'hF, 32'h0, 32'h0);
    send_access(FUNC_CFG_RD, 6'h19, 4'hF, 32'h0, 32'h0);
    send_access(FUNC_CFG_RD, 6'h18, 4'h0, 32'h0, 32'h0);
    send_access(FUNC_CFG_WR, 6'h3F, 4'hF, 32'hFFFF_FFFF, 32'h0);
    send_access(FUNC_CFG_RD, 6'h3F, 4'h5, 32'h0, 32'h0);
    // A write with no lanes enabled must leave the dword untouched.
    send_access(FUNC_CFG_WR, 6'h00, 4'h0, 32'hFFFF_FFFF, 32'h0);
    send_access(FUNC_CFG_RD, 6'h00, 4'hF, 32'h0, 32'h0);
  endtask

  task automatic test_shadow_routing();
    send_access(FUNC_MEM_RD, 6'h0, 4'h0, 32'h0, 32'h000D_FFFF);
    send_access(FUNC_MEM_RD, 6'h0, 4'h0, 32'h0, 32'h0010_0000);
    send_access(FUNC_MEM_WR, 6'h0, 4'h0, 32'h0, 32'hFFFF_FFFF);
    // With every PAM byte clear, reads go to ROM and writes are dropped.
    send_access(FUNC_MEM_RD, 6'h0, 4'h0, 32'h0, 32'h000E_0000);
    send_access(FUNC_MEM_WR, 6'h0, 4'h0, 32'h0, 32'h000E_FFFF);
    send_access(FUNC_MEM_RD, 6'h0, 4'h0, 32'h0, 32'h000F_FFFF);
    // E0000/E4000 fully enabled, E8000 read only, EC000 write only, F0000 read only.
    send_access(FUNC_CFG_WR, 6'h17, 4'hC, 32'h2133_0000, 32'h0);
    send_access(FUNC_CFG_WR, 6'h16, 4'h2, 32'h0000_1000, 32'h0);
    send_access(FUNC_MEM_RD, 6'h0, 4'h0, 32'h0, 32'h000E_3FFF);
    send_access(FUNC_MEM_WR, 6'h0, 4'h0, 32'h0, 32'h000E_4000);
    send_access(FUNC_MEM_WR, 6'h0, 4'h0, 32'h0, 32'h000E_8123);
    send_access(FUNC_MEM_RD, 6'h0, 4'h0, 32'h0, 32'h000E_C000);
    send_access(FUNC_MEM_WR, 6'h0, 4'h0, 32'h0, 32'h000E_C001);
    send_access(FUNC_MEM_RD, 6'h0, 4'h0, 32'h0, 32'h000F_8000);
    send_access(FUNC_MEM_WR, 6'h0, 4'h0, 32'h0, 32'h000F_0000);
    send_access(FUNC_CFG_RD, 6'h16, 4'hF, 32'h0, 32'h0);
    send_access(FUNC_CFG_RD, 6'h17, 4'hF, 32'h0, 32'h0);
  endtask

  // Mostly shadow-window traffic with frequent PAM rewrites; the rest is
  // boundary addresses, addresses with upper bits set and plain noise.
  task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
    func_t       f;
    logic [5:0]  idx;
    logic [31:0] addr;
    int          pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      f = (pick < 20) ? FUNC_CFG_RD : (pick < 45) ? FUNC_CFG_WR :
          (pick < 72) ? FUNC_MEM_RD : FUNC_MEM_WR;
      idx = 6'($urandom_range(63));
      if ($urandom_range(99) < 45) begin
        idx = 6'h16 + 6'($urandom_range(3));
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        addr = 32'h000E_0000 + $urandom_range(32'h1FFFF);
      end else if (pick < 80) begin
        addr = ($urandom_range(1) ? 32'h000E_0000 : 32'h0010_0000) - 4 + $urandom_range(7);
      end else if (pick < 90) begin
        addr = {12'($urandom_range(1, 12'hFFF)), 3'b111, 17'($urandom_range(17'h1FFFF))};
      end else begin
        addr = $urandom();
      end
      send_access(f, idx, 4'($urandom_range(15)), $urandom(), addr);
    end
    wait_all_results();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.func        = FUNC_CFG_RD;
    in_if.cfg_index   = '0;
    in_if.byte_enable = '0;
    in_if.write_data  = '0;
    in_if.mem_address = '0;
    out_if.ready      = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    error_count       = 0;
    results_seen      = 0;
    for (int i = 0; i < 4; i++) begin
      func_count[i]  = 0;
      route_count[i] = 0;
    end
    for (int i = 0; i < 256; i++) begin
      cfg_bytes[i] = (i >= CFG_RST_LO && i <= CFG_RST_HI) ? CFG_RST_VAL : 8'h00;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_config_defaults();
    test_shadow_routing();
    // Hold the sender off until the pipeline has fully drained.
    wait_all_results();
    test_random_traffic(488, 0, 0);
    test_random_traffic(488, 69, 0);
    test_random_traffic(488, 0, 69);
    test_random_traffic(488, 35, 35);

    recv_stall_pct = 0;
    wait_all_results();
    repeat (8) @(negedge clk);

    $display("Covered %0d config reads, %0d config writes, %0d memory reads, %0d memory writes.",
             func_count[0], func_count[1], func_count[2], func_count[3]);
    $display("Routing: %0d RAM, %0d ROM, %0d dropped, %0d outside window; %0d mismatches.",
             route_count[0], route_count[1], route_count[2], route_count[3], error_count);
    if (error_count == 0) begin
      $display("[host_bridge_pam_shadow_control_top] OK");
    end else begin
      $display("[host_bridge_pam_shadow_control_top] ERROR");
    end
    $finish;
  end

endmodule
